// ----- hw/rtl/fixed_block_pool_allocator_assert.svh -----
// ----------------------------------------------------------------------------
// Fixed block pool allocator assertion macros
// Shorthand for clocked assertions, disabled while the active-low reset is low.
// ----------------------------------------------------------------------------
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_ASSERT_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define FBPA_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define FBPA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/fbpa_pkg.sv -----
// ----------------------------------------------------------------------------
// Fixed block pool allocator package
// Field widths, codes, word types and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package fbpa_pkg;

    // Field widths.
    localparam int KIND_W   = 2;
    localparam int OFF_W    = 26;
    localparam int CNT_W    = 11;
    localparam int SIZE_W   = 17;
    localparam int STATUS_W = 2;

    // Configuration port.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register indexes (address bit 2).
    localparam logic REG_BLOCK_COUNT = 1'b0;
    localparam logic REG_BLOCK_SIZE  = 1'b1;

    // Register reset values and default pool depth.
    localparam logic [CNT_W-1:0]  BLOCK_COUNT_RESET  = 11'd1024;
    localparam logic [SIZE_W-1:0] BLOCK_SIZE_RESET   = 17'd64;
    localparam int                MAX_BLOCKS_DEFAULT = 1024;

    // Divider runs one quotient bit per step.
    localparam int DIV_STEPS = OFF_W;
    localparam int CTR_W     = $clog2(DIV_STEPS + 1);

    // Item kinds.
    localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FREE    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REBUILD = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD   = 2'd2;

    // Multiplier operand select.
    localparam logic MUL_SEL_HEAD = 1'b0;
    localparam logic MUL_SEL_POOL = 1'b1;

    // Input word.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [OFF_W-1:0]  byte_offset;
    } in_word_t;

    // Result word.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [OFF_W-1:0]    block_offset;
        logic [CNT_W-1:0]    free_count;
    } out_word_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                capture;
        logic [STATUS_W-1:0] cap_status;
        logic                build_init;
        logic                build_step;
        logic                mul_en;
        logic                mul_sel;
        logic                div_step;
        logic                alloc_pop;
        logic                free_push;
        logic                set_bad;
        logic                emit;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic free_zero;
        logic free_bad;
        logic rem_zero;
        logic walk_done;
        logic out_free;
    } dp_sts_t;

endpackage

// ----- hw/rtl/fbpa_ctrl.sv -----
// ----------------------------------------------------------------------------
// Fixed block pool allocator controller
// Sequences allocate, free and rebuild words over the datapath.
// ----------------------------------------------------------------------------
module fbpa_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [fbpa_pkg::KIND_W-1:0]   in_kind,
    input  fbpa_pkg::dp_sts_t             sts,
    output fbpa_pkg::dp_cmd_t             cmd
);

    typedef enum logic [8:0] {
        S_IDLE      = 9'b000000001,
        S_ALLOC_RD  = 9'b000000010,
        S_ALLOC_UPD = 9'b000000100,
        S_FREE_MUL  = 9'b000001000,
        S_FREE_CHK  = 9'b000010000,
        S_FREE_DIV  = 9'b000100000,
        S_FREE_PUSH = 9'b001000000,
        S_BUILD     = 9'b010000000,
        S_DONE      = 9'b100000000
    } state_t;

    state_t                     state_reg, state_next;
    logic [fbpa_pkg::CTR_W-1:0] ctr_reg, ctr_next;

    // State and divider step counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ctr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            ctr_reg   <= ctr_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

    // Next state and datapath commands.
    always_comb begin
        state_next     = state_reg;
        ctr_next       = ctr_reg;
        cmd            = '0;
        cmd.cap_status = fbpa_pkg::STATUS_OK;
        cmd.mul_sel    = fbpa_pkg::MUL_SEL_HEAD;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    ctr_next    = '0;
                    case (in_kind)
                        fbpa_pkg::KIND_ALLOC: begin
                            if (sts.free_zero) begin
                                cmd.cap_status = fbpa_pkg::STATUS_EMPTY;
                                state_next     = S_DONE;
                            end else begin
                                state_next = S_ALLOC_RD;
                            end
                        end
                        fbpa_pkg::KIND_FREE: begin
                            state_next = S_FREE_MUL;
                        end
                        fbpa_pkg::KIND_REBUILD: begin
                            cmd.build_init = 1'b1;
                            state_next     = S_BUILD;
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_ALLOC_RD: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = fbpa_pkg::MUL_SEL_HEAD;
                state_next  = S_ALLOC_UPD;
            end
            S_ALLOC_UPD: begin
                cmd.alloc_pop = 1'b1;
                state_next    = S_DONE;
            end
            S_FREE_MUL: begin
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = fbpa_pkg::MUL_SEL_POOL;
                cmd.div_step = 1'b1;
                ctr_next     = ctr_reg + 1'b1;
                state_next   = S_FREE_CHK;
            end
            S_FREE_CHK: begin
                cmd.div_step = 1'b1;
                ctr_next     = ctr_reg + 1'b1;
                if (sts.free_bad) begin
                    cmd.set_bad = 1'b1;
                    state_next  = S_DONE;
                end else begin
                    state_next = S_FREE_DIV;
                end
            end
            S_FREE_DIV: begin
                cmd.div_step = 1'b1;
                ctr_next     = ctr_reg + 1'b1;
                if (ctr_reg == fbpa_pkg::CTR_W'(fbpa_pkg::DIV_STEPS - 1)) begin
                    state_next = S_FREE_PUSH;
                end
            end
            S_FREE_PUSH: begin
                // A nonzero remainder means the offset is not on a block boundary.
                if (sts.rem_zero) begin
                    cmd.free_push = 1'b1;
                end else begin
                    cmd.set_bad = 1'b1;
                end
                state_next = S_DONE;
            end
            S_BUILD: begin
                if (sts.walk_done) begin
                    state_next = S_DONE;
                end else begin
                    cmd.build_step = 1'b1;
                end
            end
            S_DONE: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/fbpa_datapath.sv -----
// ----------------------------------------------------------------------------
// Fixed block pool allocator datapath
// Link memory, head and count registers, multiplier, divider, result register.
// ----------------------------------------------------------------------------
module fbpa_datapath #(
    parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [fbpa_pkg::CNT_W-1:0]    block_count,
    input  logic [fbpa_pkg::SIZE_W-1:0]   block_size,
    input  fbpa_pkg::in_word_t            s_data,
    input  fbpa_pkg::dp_cmd_t             cmd,
    output fbpa_pkg::dp_sts_t             sts,
    output logic                          m_valid,
    input  logic                          m_ready,
    output fbpa_pkg::out_word_t           m_data
);

    localparam int CNT_W   = fbpa_pkg::CNT_W;
    localparam int SIZE_W  = fbpa_pkg::SIZE_W;
    localparam int OFF_W   = fbpa_pkg::OFF_W;
    localparam int IDX_W   = $clog2(MAX_BLOCKS);
    localparam int MUL_A_W = (IDX_W > CNT_W) ? IDX_W : CNT_W;
    localparam int PROD_W  = MUL_A_W + SIZE_W;

    // Link memory: one entry per block, never cleared.
    logic [IDX_W-1:0] next_link [MAX_BLOCKS];

    logic [IDX_W-1:0]              head_reg;
    logic [CNT_W-1:0]              free_reg;
    logic [IDX_W-1:0]              link_rd_reg;
    logic [OFF_W-1:0]              off_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic [CNT_W-1:0]              walk_reg;
    logic [OFF_W-1:0]              qr_reg;
    logic [SIZE_W-1:0]             rem_reg;
    logic [PROD_W-1:0]             prod_reg;
    logic [fbpa_pkg::STATUS_W-1:0] res_status_reg;
    logic [OFF_W-1:0]              res_off_reg;
    logic                          m_valid_reg;
    fbpa_pkg::out_word_t           m_data_reg;

    logic [CNT_W-1:0]   cnt_eff;
    logic [MUL_A_W-1:0] mul_a;
    logic [SIZE_W:0]    trial;
    logic [SIZE_W:0]    diff;
    logic               fits;
    logic [SIZE_W-1:0]  rem_step;
    logic [IDX_W-1:0]   quot_idx;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;

    // A count above the pool depth is clamped to the depth.
    assign cnt_eff = (32'(block_count) > MAX_BLOCKS) ? CNT_W'(MAX_BLOCKS) : block_count;

    // Multiplier operand: head index for an allocate, block count for the pool size.
    assign mul_a = (cmd.mul_sel == fbpa_pkg::MUL_SEL_POOL) ? MUL_A_W'(cnt_reg)
                                                           : MUL_A_W'(head_reg);

    // One restoring division step: bring in the next dividend bit and try a subtract.
    assign trial    = {rem_reg, qr_reg[OFF_W-1]};
    assign fits     = (trial >= {1'b0, block_size});
    assign diff     = trial - {1'b0, block_size};
    assign rem_step = fits ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
    assign quot_idx = qr_reg[IDX_W-1:0];

    // Link writes come from the rebuild walk or from a free.
    assign mem_we    = cmd.build_step || cmd.free_push;
    assign mem_waddr = cmd.build_step ? IDX_W'(walk_reg) : quot_idx;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            next_link[mem_waddr] <= head_reg;
        end
        link_rd_reg <= next_link[head_reg];
    end

    // Free list head, free count and result valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            free_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.build_init) begin
                head_reg <= '0;
                free_reg <= '0;
            end else if (cmd.build_step) begin
                head_reg <= IDX_W'(walk_reg);
                free_reg <= free_reg + 1'b1;
            end else if (cmd.alloc_pop) begin
                head_reg <= link_rd_reg;
                free_reg <= free_reg - 1'b1;
            end else if (cmd.free_push) begin
                head_reg <= quot_idx;
                free_reg <= free_reg + 1'b1;
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Word capture, arithmetic and result fields.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            off_reg        <= s_data.byte_offset;
            cnt_reg        <= cnt_eff;
            qr_reg         <= s_data.byte_offset;
            rem_reg        <= '0;
            res_status_reg <= cmd.cap_status;
            res_off_reg    <= '0;
        end else begin
            if (cmd.div_step) begin
                qr_reg  <= {qr_reg[OFF_W-2:0], fits};
                rem_reg <= rem_step;
            end
            if (cmd.set_bad) begin
                res_status_reg <= fbpa_pkg::STATUS_BAD;
            end
            if (cmd.alloc_pop) begin
                res_off_reg <= prod_reg[OFF_W-1:0];
            end
        end
        if (cmd.build_init) begin
            walk_reg <= '0;
        end else if (cmd.build_step) begin
            walk_reg <= walk_reg + 1'b1;
        end
        if (cmd.mul_en) begin
            prod_reg <= PROD_W'(mul_a) * PROD_W'(block_size);
        end
        if (cmd.emit) begin
            m_data_reg.status       <= res_status_reg;
            m_data_reg.block_offset <= res_off_reg;
            m_data_reg.free_count   <= free_reg;
        end
    end

    // Status back to the controller.
    always_comb begin
        sts.free_zero = (free_reg == '0);
        sts.free_bad  = (block_size == '0) || (PROD_W'(off_reg) >= prod_reg) ||
                        (free_reg >= cnt_reg);
        sts.rem_zero  = (rem_reg == '0);
        sts.walk_done = (walk_reg == cnt_reg);
        sts.out_free  = !m_valid_reg || m_ready;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ----- hw/rtl/fixed_block_pool_allocator.sv -----
// Allocate: S_ALLOC_RD (multiply) and S_ALLOC_UPD (pop), then S_DONE emits; the next word is taken after that.
// Free: the result is set by the one-bit-per-cycle divider (26 steps).
// A free that fails the range or count check returns from S_FREE_CHK without the full division.
// Rebuild: one link memory write per block.
// Reset clears head and free count and sets block_count 1024, block_size 64;
// the link memory is not cleared.
// ----------------------------------------------------------------------------
// Fixed block pool allocator
// LIFO free list of equal-size blocks with an APB register port.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator #(
    parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [fbpa_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [fbpa_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [fbpa_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  fbpa_pkg::in_word_t                s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output fbpa_pkg::out_word_t               m_data
);

    logic [fbpa_pkg::CNT_W-1:0]  block_count_reg;
    logic [fbpa_pkg::SIZE_W-1:0] block_size_reg;
    logic                        cfg_wr;
    fbpa_pkg::dp_cmd_t           cmd;
    fbpa_pkg::dp_sts_t           sts;

    // Configuration registers.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_count_reg <= fbpa_pkg::BLOCK_COUNT_RESET;
            block_size_reg  <= fbpa_pkg::BLOCK_SIZE_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                fbpa_pkg::REG_BLOCK_COUNT: block_count_reg <= pwdata[fbpa_pkg::CNT_W-1:0];
                fbpa_pkg::REG_BLOCK_SIZE:  block_size_reg  <= pwdata[fbpa_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // Register read back.
    always_comb begin
        unique case (paddr[2])
            fbpa_pkg::REG_BLOCK_COUNT: prdata = fbpa_pkg::APB_DATA_W'(block_count_reg);
            fbpa_pkg::REG_BLOCK_SIZE:  prdata = fbpa_pkg::APB_DATA_W'(block_size_reg);
            default:                   prdata = '0;
        endcase
    end

    fbpa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .in_kind (s_data.kind),
        .sts     (sts),
        .cmd     (cmd)
    );

    fbpa_datapath #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .block_count (block_count_reg),
        .block_size  (block_size_reg),
        .s_data      (s_data),
        .cmd         (cmd),
        .sts         (sts),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

// ----- hw/rtl/fbpa_checker.sv -----
// ----------------------------------------------------------------------------
// Fixed block pool allocator checker
// Port-level assertions on the word channels, bound to the top level.
// ----------------------------------------------------------------------------
`include "fixed_block_pool_allocator_assert.svh"

module fbpa_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input fbpa_pkg::in_word_t  s_data,
    input logic                m_valid,
    input logic                m_ready,
    input fbpa_pkg::out_word_t m_data
);

    // A stalled result word holds.
    `FBPA_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "result word changed while stalled")

    // The block works on one word at a time.
    `FBPA_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready, "input accepted while a word is in progress")

    // No result can appear in the cycle right after an accept.
    `FBPA_ASSERT_NEXT(a_no_instant_result, aclk, aresetn, s_valid && s_ready, !$rose(m_valid), "result appeared too early")

    // An empty-pool result always reports no free blocks and no offset.
    `FBPA_ASSERT_SAME(a_empty_consistent, aclk, aresetn, m_valid && (m_data.status == fbpa_pkg::STATUS_EMPTY), (m_data.free_count == '0) && (m_data.block_offset == '0), "empty status with free blocks")

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
